// File: rtl/pls_pkg.sv
// shared types and constants for the positional list store
package pls_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_INSERT     = 3'd1;
    localparam logic [2:0] CMD_REMOVE_END = 3'd2;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd3;
    localparam logic [2:0] CMD_SHOW       = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
    } cell_ctl_t;

endpackage

// File: rtl/pls_cell.sv
// one storage cell of the list chain
module pls_cell (
    input  logic                              clk,
    input  logic [pls_pkg::IDX_W-1:0]         idx,
    input  pls_pkg::cell_ctl_t                ctl,
    input  logic signed [pls_pkg::VAL_W-1:0]  prev_value,
    input  logic signed [pls_pkg::VAL_W-1:0]  next_value,
    input  logic signed [pls_pkg::VAL_W-1:0]  new_value,
    output logic signed [pls_pkg::VAL_W-1:0]  value
);

    logic signed [pls_pkg::VAL_W-1:0] value_reg;
    logic signed [pls_pkg::VAL_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            pls_pkg::OP_INSERT:
            begin
                // cells past the insert point move back one place
                if (idx > ctl.idx)
                    value_next = prev_value;
                else if (idx == ctl.idx)
                    value_next = new_value;
            end
            pls_pkg::OP_REMOVE:
            begin
                if (idx >= ctl.idx)
                    value_next = next_value;
            end
            pls_pkg::OP_ROTATE:
            begin
                // head wraps into the last occupied cell
                if (idx == ctl.idx)
                    value_next = new_value;
                else
                    value_next = next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/positional_list_store_core.sv
// positional list store top level: command decode, cell chain, result register
// Keeps an ordered list of up to 16 signed 32-bit values in a chain of cells.
// Append, insert, remove-last, remove-at and unused commands each take one item
// per cycle unless a stalled full result register holds off input; a valid
// edit shifts the cells from its point on toward or away from their neighbors
// in the same cycle, and the single result appears in the next cycle. Show on
// a non-empty list gives one result per stored element, one per cycle unless
// stalled, by rotating the chain via its head cell; input waits for the last.
module positional_list_store_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [2:0]                        cmd,
    input  logic [pls_pkg::POS_W-1:0]         position,
    input  logic signed [pls_pkg::VAL_W-1:0]  item_value,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [pls_pkg::VAL_W-1:0]  element_value,
    output logic [pls_pkg::CNT_W-1:0]         element_count,
    output logic [1:0]                        status,
    output logic                              last_item
);

    logic signed [pls_pkg::VAL_W-1:0] cell_value [pls_pkg::DEPTH];
    logic signed [pls_pkg::VAL_W-1:0] new_value;
    logic signed [pls_pkg::VAL_W-1:0] picked_value;
    pls_pkg::cell_ctl_t               ctl;

    logic [pls_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      busy_reg, busy_next;
    logic [pls_pkg::IDX_W-1:0] show_idx_reg, show_idx_next;

    logic                              res_valid_reg, res_valid_next;
    logic signed [pls_pkg::VAL_W-1:0]  res_value_reg, res_value_next;
    logic [pls_pkg::CNT_W-1:0]         res_count_reg, res_count_next;
    logic [1:0]                        res_status_reg, res_status_next;
    logic                              res_last_reg, res_last_next;

    logic                      res_free;
    logic                      res_load;
    logic                      cmd_accept;
    logic [pls_pkg::IDX_W-1:0] tail_idx;
    logic [pls_pkg::IDX_W-1:0] pick_idx;
    logic [pls_pkg::POS_W:0]   pos_ext;
    logic [pls_pkg::POS_W:0]   count_ext;
    logic                      full;
    logic                      empty;

    assign res_free   = !res_valid_reg || !result_stall;
    assign cmd_stall  = busy_reg || !res_free;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign tail_idx   = pls_pkg::IDX_W'(count_reg - pls_pkg::CNT_W'(1));
    assign pos_ext    = {1'b0, position};
    assign count_ext  = (pls_pkg::POS_W + 1)'(count_reg);
    assign full       = count_reg >= pls_pkg::CNT_W'(pls_pkg::DEPTH);
    assign empty      = count_reg == '0;
    assign pick_idx   = (cmd == pls_pkg::CMD_REMOVE_AT) ?
                        pls_pkg::IDX_W'(position - pls_pkg::POS_W'(1)) : tail_idx;

    // the cell chain
    for (genvar i = 0; i < pls_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [pls_pkg::VAL_W-1:0] prev_v;
        logic signed [pls_pkg::VAL_W-1:0] next_v;

        if (i == 0)
        begin : g_first
            assign prev_v = '0;
        end
        else
        begin : g_mid_prev
            assign prev_v = cell_value[i-1];
        end

        if (i == pls_pkg::DEPTH - 1)
        begin : g_last
            assign next_v = '0;
        end
        else
        begin : g_mid_next
            assign next_v = cell_value[i+1];
        end

        pls_cell u_cell (
            .clk        (clk),
            .idx        (pls_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .prev_value (prev_v),
            .next_value (next_v),
            .new_value  (new_value),
            .value      (cell_value[i])
        );
    end

    // value of the cell being removed
    always_comb
    begin
        picked_value = '0;
        for (int i = 0; i < pls_pkg::DEPTH; i++)
        begin
            if (pick_idx == pls_pkg::IDX_W'(i))
                picked_value = picked_value | cell_value[i];
        end
    end

    always_comb
    begin
        ctl.op          = pls_pkg::OP_HOLD;
        ctl.idx         = '0;
        new_value       = item_value;
        count_next      = count_reg;
        busy_next       = busy_reg;
        show_idx_next   = show_idx_reg;
        res_load        = 1'b0;
        res_value_next  = '0;
        res_count_next  = count_reg;
        res_status_next = pls_pkg::ST_OK;
        res_last_next   = 1'b1;

        if (busy_reg)
        begin
            if (res_free)
            begin
                ctl.op         = pls_pkg::OP_ROTATE;
                ctl.idx        = tail_idx;
                new_value      = cell_value[0];
                res_load       = 1'b1;
                res_value_next = cell_value[0];
                res_last_next  = show_idx_reg == tail_idx;
                if (show_idx_reg == tail_idx)
                    busy_next = 1'b0;
                show_idx_next = show_idx_reg + pls_pkg::IDX_W'(1);
            end
        end
        else if (cmd_accept)
        begin
            res_load = 1'b1;
            case (cmd)
                pls_pkg::CMD_APPEND:
                begin
                    if (full)
                        res_status_next = pls_pkg::ST_FULL;
                    else
                    begin
                        ctl.op     = pls_pkg::OP_INSERT;
                        ctl.idx    = pls_pkg::IDX_W'(count_reg);
                        count_next = count_reg + pls_pkg::CNT_W'(1);
                    end
                end
                pls_pkg::CMD_INSERT:
                begin
                    if (full)
                        res_status_next = pls_pkg::ST_FULL;
                    else if (position == '0 ||
                             pos_ext > count_ext + (pls_pkg::POS_W + 1)'(1))
                        res_status_next = pls_pkg::ST_BADPOS;
                    else
                    begin
                        ctl.op     = pls_pkg::OP_INSERT;
                        ctl.idx    = pls_pkg::IDX_W'(position - pls_pkg::POS_W'(1));
                        count_next = count_reg + pls_pkg::CNT_W'(1);
                    end
                end
                pls_pkg::CMD_REMOVE_END:
                begin
                    if (empty)
                        res_status_next = pls_pkg::ST_EMPTY;
                    else
                    begin
                        ctl.op         = pls_pkg::OP_REMOVE;
                        ctl.idx        = tail_idx;
                        res_value_next = picked_value;
                        count_next     = count_reg - pls_pkg::CNT_W'(1);
                    end
                end
                pls_pkg::CMD_REMOVE_AT:
                begin
                    if (empty)
                        res_status_next = pls_pkg::ST_EMPTY;
                    else if (position == '0 || pos_ext > count_ext)
                        res_status_next = pls_pkg::ST_BADPOS;
                    else
                    begin
                        ctl.op         = pls_pkg::OP_REMOVE;
                        ctl.idx        = pls_pkg::IDX_W'(position - pls_pkg::POS_W'(1));
                        res_value_next = picked_value;
                        count_next     = count_reg - pls_pkg::CNT_W'(1);
                    end
                end
                pls_pkg::CMD_SHOW:
                begin
                    if (empty)
                        res_status_next = pls_pkg::ST_EMPTY;
                    else
                    begin
                        // results come from the rotation cycles that follow
                        res_load      = 1'b0;
                        busy_next     = 1'b1;
                        show_idx_next = '0;
                    end
                end
                default:
                begin
                    res_status_next = pls_pkg::ST_OK;
                end
            endcase
            res_count_next = count_next;
        end
    end

    assign res_valid_next = res_load ? 1'b1 : (res_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            show_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            show_idx_reg  <= show_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_value_reg  <= res_value_next;
            res_count_reg  <= res_count_next;
            res_status_reg <= res_status_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign result_valid  = res_valid_reg;
    assign element_value = res_value_reg;
    assign element_count = res_count_reg;
    assign status        = res_status_reg;
    assign last_item     = res_last_reg;

endmodule

// File: bench/tb_top.sv
// testbench for the positional list store: directed and random commands against a list predictor
`timescale 1ns / 100ps

module tb_top;

    // command codes the block does not use
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;

    localparam logic signed [pls_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [pls_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [pls_pkg::VAL_W-1:0] value;
        logic [pls_pkg::CNT_W-1:0]        count;
        logic [1:0]                       code;
        logic                             is_last;
    } list_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cmd_valid = 1'b0;
    logic                               cmd_stall;
    logic [2:0]                         cmd = pls_pkg::CMD_APPEND;
    logic [pls_pkg::POS_W-1:0]          position = '0;
    logic signed [pls_pkg::VAL_W-1:0]   item_value = '0;
    logic                               result_valid;
    logic                               result_stall = 1'b0;
    logic signed [pls_pkg::VAL_W-1:0]   element_value;
    logic [pls_pkg::CNT_W-1:0]          element_count;
    logic [1:0]                         status;
    logic                               last_item;

    // predictor state
    logic signed [pls_pkg::VAL_W-1:0]   list_cells [pls_pkg::DEPTH];
    int                                 list_len;
    list_result_t                       due_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int commands_sent;
    int results_checked;
    int show_count;
    int status_tally [4];
    bit growing;

    positional_list_store_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .position      (position),
        .item_value    (item_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .element_value (element_value),
        .element_count (element_count),
        .status        (status),
        .last_item     (last_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    function automatic void push_result(input logic signed [pls_pkg::VAL_W-1:0] value,
                                        input logic [1:0] code, input logic is_last);
        list_result_t r;
        r.value   = value;
        r.count   = pls_pkg::CNT_W'(list_len);
        r.code    = code;
        r.is_last = is_last;
        due_results.push_back(r);
        status_tally[code]++;
    endfunction

    // updates the list and queues the results one command must produce
    function automatic void apply_list_command(input logic [2:0] op,
                                               input logic [pls_pkg::POS_W-1:0] pos,
                                               input logic signed [pls_pkg::VAL_W-1:0] val);
        int i;
        logic signed [pls_pkg::VAL_W-1:0] removed;
        case (op)
            pls_pkg::CMD_APPEND:
            begin
                if (list_len >= pls_pkg::DEPTH)
                    push_result('0, pls_pkg::ST_FULL, 1'b1);
                else
                begin
                    list_cells[list_len] = val;
                    list_len++;
                    push_result('0, pls_pkg::ST_OK, 1'b1);
                end
            end
            pls_pkg::CMD_INSERT:
            begin
                if (list_len >= pls_pkg::DEPTH)
                    push_result('0, pls_pkg::ST_FULL, 1'b1);
                else if (pos == 0 || pos > list_len + 1)
                    push_result('0, pls_pkg::ST_BADPOS, 1'b1);
                else
                begin
                    for (i = list_len; i >= pos; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[pos-1] = val;
                    list_len++;
                    push_result('0, pls_pkg::ST_OK, 1'b1);
                end
            end
            pls_pkg::CMD_REMOVE_END:
            begin
                if (list_len == 0)
                    push_result('0, pls_pkg::ST_EMPTY, 1'b1);
                else
                begin
                    list_len--;
                    push_result(list_cells[list_len], pls_pkg::ST_OK, 1'b1);
                end
            end
            pls_pkg::CMD_REMOVE_AT:
            begin
                // empty wins over a bad position
                if (list_len == 0)
                    push_result('0, pls_pkg::ST_EMPTY, 1'b1);
                else if (pos == 0 || pos > list_len)
                    push_result('0, pls_pkg::ST_BADPOS, 1'b1);
                else
                begin
                    removed = list_cells[pos-1];
                    for (i = pos - 1; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                    push_result(removed, pls_pkg::ST_OK, 1'b1);
                end
            end
            pls_pkg::CMD_SHOW:
            begin
                show_count++;
                if (list_len == 0)
                    push_result('0, pls_pkg::ST_EMPTY, 1'b1);
                else
                    for (i = 0; i < list_len; i++)
                        push_result(list_cells[i], pls_pkg::ST_OK, i == list_len - 1);
            end
            default:
                push_result('0, pls_pkg::ST_OK, 1'b1);
        endcase
    endfunction

    // idles the sender for a random number of cycles, then drives one item
    // and waits until the block takes it
    task automatic send_item(input logic [2:0] op, input logic [pls_pkg::POS_W-1:0] pos,
                             input logic signed [pls_pkg::VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd        <= op;
        position   <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (cmd_stall);
        apply_list_command(op, pos, val);
        commands_sent++;
    endtask

    task automatic check_result();
        list_result_t want;
        if (due_results.size() == 0)
        begin
            $error("result item with no command outstanding");
            error_count++;
        end
        else
        begin
            want = due_results.pop_front();
            results_checked++;
            if (element_value !== want.value)
            begin
                $error("element_value: expected %0d, got %0d", want.value, element_value);
                error_count++;
            end
            if (element_count !== want.count)
            begin
                $error("element_count: expected %0d, got %0d", want.count, element_count);
                error_count++;
            end
            if (status !== want.code)
            begin
                $error("status: expected %0d, got %0d", want.code, status);
                error_count++;
            end
            if (last_item !== want.is_last)
            begin
                $error("last_item: expected %0b, got %0b", want.is_last, last_item);
                error_count++;
            end
        end
    endtask

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            check_result();

    function automatic logic signed [pls_pkg::VAL_W-1:0] pick_value();
        logic signed [pls_pkg::VAL_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0)
            case ($urandom_range(0, 3))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = '0;
                default: v = '1;
            endcase
        return v;
    endfunction

    task automatic test_empty_list();
        send_item(pls_pkg::CMD_SHOW, 5'd1, VAL_MAX);
        send_item(pls_pkg::CMD_REMOVE_END, 5'd1, '0);
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd0, '0);
        send_item(pls_pkg::CMD_INSERT, 5'd0, 32'sd5);
        send_item(pls_pkg::CMD_INSERT, 5'd2, 32'sd5);
        send_item(CMD_UNUSED_LO, 5'd31, VAL_MIN);
        send_item(CMD_UNUSED_MID, 5'd16, '1);
        send_item(CMD_UNUSED_HI, 5'd31, VAL_MAX);
    endtask

    task automatic test_edit_positions();
        send_item(pls_pkg::CMD_INSERT, 5'd1, VAL_MAX);
        send_item(pls_pkg::CMD_APPEND, 5'd0, VAL_MIN);
        send_item(pls_pkg::CMD_INSERT, 5'd1, '1);               // new head
        send_item(pls_pkg::CMD_INSERT, 5'd4, '0);               // one past the tail
        send_item(pls_pkg::CMD_INSERT, 5'd3, 32'sh5a5a_a5a5);
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd0, '0);
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd6, '0);
        send_item(pls_pkg::CMD_SHOW, 5'd0, '0);
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd1, '0);            // head
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd4, '0);            // tail
        send_item(pls_pkg::CMD_REMOVE_AT, 5'd2, '0);
        send_item(pls_pkg::CMD_REMOVE_END, 5'd0, '0);
        send_item(pls_pkg::CMD_SHOW, 5'd0, '0);
    endtask

    task automatic test_full_list();
        while (list_len < pls_pkg::DEPTH)
            if (list_len % 2 == 0)
                send_item(pls_pkg::CMD_INSERT, 5'd1, pick_value());
            else
                send_item(pls_pkg::CMD_APPEND, 5'd31, pick_value());
        send_item(pls_pkg::CMD_APPEND, 5'd0, VAL_MAX);
        // full is reported before the bad position
        send_item(pls_pkg::CMD_INSERT, 5'd31, VAL_MIN);
        send_item(pls_pkg::CMD_INSERT, 5'd1, '1);
        send_item(pls_pkg::CMD_SHOW, 5'd0, '0);
    endtask

    task automatic random_command();
        logic [2:0]                op;
        logic [pls_pkg::POS_W-1:0] pos;
        int                        r;
        if (list_len == 0)
            growing = 1'b1;
        else if (list_len == pls_pkg::DEPTH)
            growing = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (r < 12)
            op = pls_pkg::CMD_SHOW;
        else if (r < (growing ? 68 : 35))
            op = $urandom_range(0, 1) ? pls_pkg::CMD_APPEND : pls_pkg::CMD_INSERT;
        else
            op = $urandom_range(0, 1) ? pls_pkg::CMD_REMOVE_END : pls_pkg::CMD_REMOVE_AT;
        // mostly legal positions, some out of range anywhere in the field
        if ($urandom_range(0, 9) == 0)
            pos = pls_pkg::POS_W'($urandom);
        else if (op == pls_pkg::CMD_INSERT)
            pos = pls_pkg::POS_W'($urandom_range(1, list_len + 1));
        else if (op == pls_pkg::CMD_REMOVE_AT && list_len > 0)
            pos = pls_pkg::POS_W'($urandom_range(1, list_len));
        else
            pos = pls_pkg::POS_W'($urandom);
        send_item(op, pos, pick_value());
    endtask

    task automatic test_random_ops();
        int n;
        for (n = 0; n < 320; n++)
        begin
            if (n == 107)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 12;
            end
            else if (n == 214)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_command();
        end
    endtask

    initial
    begin
        list_len      = 0;
        error_count   = 0;
        commands_sent = 0;
        results_checked = 0;
        show_count    = 0;
        status_tally  = '{4{0}};
        growing       = 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 77;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edit_positions();
        test_full_list();
        test_random_ops();

        cmd_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d commands (%0d shows), checked %0d result items",
                 commands_sent, show_count, results_checked);
        $display("status seen: ok %0d, full %0d, empty %0d, bad position %0d",
                 status_tally[pls_pkg::ST_OK], status_tally[pls_pkg::ST_FULL],
                 status_tally[pls_pkg::ST_EMPTY], status_tally[pls_pkg::ST_BADPOS]);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d result items outstanding", due_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
